>>> hdl/xcrng_pkg.sv
// xcrng_pkg.sv: shared types, constants and the microcode table of the xtea counter-mode generator
`timescale 1ns / 1ps

package xcrng_pkg;

  localparam int unsigned RoundsDefault = 64;
  localparam logic [31:0] XteaDelta     = 32'h9E37_79B9;
  localparam logic [15:0] RekeyReset    = 16'd21;
  localparam logic [15:0] BlockCountMax = 16'hFFFF;

  localparam logic [31:0] KeyReset0 = 32'h0000_0000;
  localparam logic [31:0] KeyReset1 = 32'h3b6e_20c8;
  localparam logic [31:0] KeyReset2 = 32'h76dc_4190;
  localparam logic [31:0] KeyReset3 = 32'h4db2_6158;

  localparam int unsigned StepW = 3;
  typedef logic [StepW-1:0] step_t;

  localparam step_t StepWaitIn  = 3'd0;
  localparam step_t StepLoadTs  = 3'd1;
  localparam step_t StepEncLo   = 3'd2;
  localparam step_t StepLoadK1  = 3'd3;
  localparam step_t StepEncHi   = 3'd4;
  localparam step_t StepLoadK2  = 3'd5;
  localparam step_t StepEncOut  = 3'd6;
  localparam step_t StepPush    = 3'd7;

  // jump conditions: taken goes to target, otherwise stay or fall through
  typedef enum logic [2:0] {
    CondAlways  = 3'd0,
    CondInFire  = 3'd1,
    CondNoRekey = 3'd2,
    CondEncDone = 3'd3,
    CondOutFree = 3'd4
  } cond_e;

  typedef enum logic [1:0] {
    LdNone   = 2'd0,
    LdTsCtr  = 2'd1,
    LdCtrP1  = 2'd2,
    LdCtrP2  = 2'd3
  } load_e;

  typedef enum logic [1:0] {
    KwNone = 2'd0,
    KwLo   = 2'd1,
    KwHi   = 2'd2
  } keywr_e;

  typedef struct packed {
    cond_e  cond;
    step_t  target;
    logic   stay;
    logic   in_ready;
    load_e  load;
    logic   enc;
    keywr_e key_wr;
    logic   rekey_upd;
    logic   out_push;
  } ctrl_t;

  typedef struct packed {
    logic rekey;
    logic enc_done;
    logic in_fire;
    logic out_free;
  } status_t;

  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t c;
    c = '{cond: CondAlways, target: StepWaitIn, stay: 1'b0, in_ready: 1'b0, load: LdNone,
          enc: 1'b0, key_wr: KwNone, rekey_upd: 1'b0, out_push: 1'b0};
    unique case (step)
      StepWaitIn: begin
        c.cond = CondInFire; c.target = StepLoadTs; c.stay = 1'b1; c.in_ready = 1'b1;
      end
      StepLoadTs: begin
        c.cond = CondNoRekey; c.target = StepEncOut; c.load = LdTsCtr;
      end
      StepEncLo: begin
        c.cond = CondEncDone; c.target = StepLoadK1; c.stay = 1'b1; c.enc = 1'b1;
      end
      StepLoadK1: begin
        c.target = StepEncHi; c.load = LdCtrP1; c.key_wr = KwLo;
      end
      StepEncHi: begin
        c.cond = CondEncDone; c.target = StepLoadK2; c.stay = 1'b1; c.enc = 1'b1;
      end
      StepLoadK2: begin
        c.target = StepEncOut; c.load = LdCtrP2; c.key_wr = KwHi; c.rekey_upd = 1'b1;
      end
      StepEncOut: begin
        c.cond = CondEncDone; c.target = StepPush; c.stay = 1'b1; c.enc = 1'b1;
      end
      StepPush: begin
        c.cond = CondOutFree; c.target = StepWaitIn; c.stay = 1'b1; c.out_push = 1'b1;
      end
      default: ;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/xcrng_seq.sv
// xcrng_seq.sv: step counter and microcode fetch with conditional jumps
`timescale 1ns / 1ps

module xcrng_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  xcrng_pkg::status_t status_i,
  output xcrng_pkg::ctrl_t   ctrl_o
);

  xcrng_pkg::step_t step_q, step_d;
  logic             taken;

  assign ctrl_o = xcrng_pkg::ucode_rom(step_q);

  always_comb begin
    unique case (ctrl_o.cond)
      xcrng_pkg::CondAlways:  taken = 1'b1;
      xcrng_pkg::CondInFire:  taken = status_i.in_fire;
      xcrng_pkg::CondNoRekey: taken = !status_i.rekey;
      xcrng_pkg::CondEncDone: taken = status_i.enc_done;
      xcrng_pkg::CondOutFree: taken = status_i.out_free;
      default:                taken = 1'b0;
    endcase
  end

  always_comb begin
    if (taken) begin
      step_d = ctrl_o.target;
    end else if (ctrl_o.stay) begin
      step_d = step_q;
    end else begin
      step_d = step_q + xcrng_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= xcrng_pkg::StepWaitIn;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

>>> hdl/xcrng_dpath.sv
// xcrng_dpath.sv: key, counters and the half-round xtea datapath
`timescale 1ns / 1ps

module xcrng_dpath #(
  parameter int unsigned Rounds = xcrng_pkg::RoundsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  xcrng_pkg::ctrl_t ctrl_i,
  input  logic             in_fire_i,
  input  logic [31:0]      timestamp_i,
  input  logic             push_i,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_data_i,
  output logic             rekey_o,
  output logic             enc_done_o,
  output logic [63:0]      block_o
);

  localparam int unsigned RoundW = $clog2(Rounds);

  logic [31:0]       key_q [4];
  logic [31:0]       ts_q;
  logic [31:0]       ctr_q, ctr_d;
  logic [15:0]       bsr_q, bsr_d;
  logic [15:0]       thr_q;
  logic [31:0]       v0_q, v0_d, v1_q, v1_d, sum_q, sum_d;
  logic              half_q, half_d;
  logic [RoundW-1:0] round_q, round_d;

  logic [31:0] x, mix, kword, t;
  logic [1:0]  kidx;

  assign rekey_o    = bsr_q >= thr_q;
  assign enc_done_o = ctrl_i.enc && half_q && (round_q == RoundW'(Rounds - 1));
  assign block_o    = {v0_q, v1_q};

  // one half of an xtea cycle per clock
  always_comb begin
    x     = half_q ? v0_q : v1_q;
    kidx  = half_q ? sum_q[12:11] : sum_q[1:0];
    kword = key_q[kidx];
    mix   = ((x << 4) ^ (x >> 5)) + x;
    t     = mix ^ (sum_q + kword);
  end

  always_comb begin
    v0_d    = v0_q;
    v1_d    = v1_q;
    sum_d   = sum_q;
    half_d  = half_q;
    round_d = round_q;
    if (ctrl_i.load != xcrng_pkg::LdNone) begin
      v0_d    = ts_q;
      sum_d   = '0;
      half_d  = 1'b0;
      round_d = '0;
      case (ctrl_i.load)
        xcrng_pkg::LdTsCtr: v1_d = ts_q + ctr_q;
        xcrng_pkg::LdCtrP1: v1_d = ctr_q + 32'd1;
        default:            v1_d = ctr_q + 32'd2;
      endcase
    end else if (ctrl_i.enc) begin
      half_d = !half_q;
      if (!half_q) begin
        v0_d  = v0_q + t;
        sum_d = sum_q + xcrng_pkg::XteaDelta;
      end else begin
        v1_d    = v1_q + t;
        round_d = round_q + RoundW'(1);
      end
    end
  end

  always_comb begin
    ctr_d = ctr_q;
    bsr_d = bsr_q;
    if (ctrl_i.rekey_upd) begin
      ctr_d = ctr_q + 32'd2;
      bsr_d = '0;
    end else if (push_i) begin
      ctr_d = ctr_q + 32'd1;
      if (bsr_q != xcrng_pkg::BlockCountMax) begin
        bsr_d = bsr_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= xcrng_pkg::KeyReset0;
      key_q[1] <= xcrng_pkg::KeyReset1;
      key_q[2] <= xcrng_pkg::KeyReset2;
      key_q[3] <= xcrng_pkg::KeyReset3;
      ctr_q    <= '0;
      bsr_q    <= '0;
      thr_q    <= xcrng_pkg::RekeyReset;
      half_q   <= 1'b0;
      round_q  <= '0;
    end else begin
      // key words take the finished ciphertext before the next load replaces it
      case (ctrl_i.key_wr)
        xcrng_pkg::KwLo: begin
          key_q[0] <= v0_q;
          key_q[1] <= v1_q;
        end
        xcrng_pkg::KwHi: begin
          key_q[2] <= v0_q;
          key_q[3] <= v1_q;
        end
        default: ;
      endcase
      ctr_q   <= ctr_d;
      bsr_q   <= bsr_d;
      half_q  <= half_d;
      round_q <= round_d;
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v0_q  <= v0_d;
    v1_q  <= v1_d;
    sum_q <= sum_d;
    if (in_fire_i) begin
      ts_q <= timestamp_i;
    end
  end

endmodule

>>> hdl/xtea_counter_mode_rng.sv
// xtea_counter_mode_rng.sv: top level of the microcoded xtea counter-mode generator
//
//  channel   | direction | payload                      | transfer when
//  s_axis    | in        | tdata[31:0]  timestamp       | s_axis_tvalid_i & s_axis_tready_o
//  m_axis    | out       | tdata[63:0]  random_value    | m_axis_tvalid_o & m_axis_tready_i
//  cfg       | in        | data[15:0]   rekey_threshold | cfg_valid_i & cfg_ready_o
//
//  each item is enciphered by the single xtea half-round unit, which runs one half-cycle per clock;
//  a rekey enciphers the two key halves on the same unit before the output block.
//  reset: asynchronous, active low; key, counters and threshold return to their initial values.
//  a new timestamp is taken while the previous result still waits in the output register;
//  the sequencer only stalls in its push step when that register is still full.
`timescale 1ns / 1ps

module xtea_counter_mode_rng #(
  parameter int unsigned Rounds = xcrng_pkg::RoundsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] timestamp
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] random_value
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  xcrng_pkg::ctrl_t   ctrl;
  xcrng_pkg::status_t status;
  logic               in_fire, push, out_free;
  logic               rekey, enc_done;
  logic [63:0]        block;
  logic               out_valid_q;
  logic [63:0]        out_data_q;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = ctrl.in_ready;
  assign in_fire         = s_axis_tvalid_i && ctrl.in_ready;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign push            = ctrl.out_push && out_free;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign status = '{rekey: rekey, enc_done: enc_done, in_fire: in_fire, out_free: out_free};

  xcrng_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  xcrng_dpath #(
    .Rounds (Rounds)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_fire_i   (in_fire),
    .timestamp_i (s_axis_tdata_i),
    .push_i      (push),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .rekey_o     (rekey),
    .enc_done_o  (enc_done),
    .block_o     (block)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_data_q <= block;
    end
  end

endmodule

>>> dv/xtea_rng_checker.sv
// xtea_rng_checker.sv: predicts each random value of the xtea generator and checks the output stream
`timescale 1ns / 1ps

module xtea_rng_checker #(
  parameter int unsigned Rounds = xcrng_pkg::RoundsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [31:0] s_data_i,      // [31:0] timestamp
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [63:0] m_data_i,      // [63:0] random_value
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  typedef logic [31:0] word_t;
  typedef logic [3:0][31:0] key_t;

  key_t        key_q;
  word_t       ctr_q;
  logic [15:0] since_rekey_q;
  logic [15:0] threshold_q;
  logic [63:0] random_q[$];
  int unsigned fails;

  assign fail_count_o = fails;

  function automatic logic [63:0] xtea_encipher(input word_t v0_in, input word_t v1_in,
                                                input key_t key);
    word_t v0;
    word_t v1;
    word_t sum;
    int    r;
    v0  = v0_in;
    v1  = v1_in;
    sum = '0;
    for (r = 0; r < Rounds; r++) begin
      v0  = v0 + ((((v1 << 4) ^ (v1 >> 5)) + v1) ^ (sum + key[sum[1:0]]));
      sum = sum + xcrng_pkg::XteaDelta;
      v1  = v1 + ((((v0 << 4) ^ (v0 >> 5)) + v0) ^ (sum + key[sum[12:11]]));
    end
    return {v0, v1};
  endfunction

  // advances the generator state by one timestamp and returns the value it issues
  function automatic logic [63:0] next_random(input word_t ts);
    logic [63:0] c;
    word_t       second;
    second = ts + ctr_q;
    if (since_rekey_q >= threshold_q) begin
      c = xtea_encipher(ts, ts + ctr_q, key_q);
      key_q[0] = c[63:32];
      key_q[1] = c[31:0];
      c = xtea_encipher(ts, ctr_q + 32'd1, key_q);
      key_q[2] = c[63:32];
      key_q[3] = c[31:0];
      second = ctr_q + 32'd2;
      ctr_q  = ctr_q + 32'd2;
      since_rekey_q = '0;
    end
    c = xtea_encipher(ts, second, key_q);
    if (since_rekey_q != xcrng_pkg::BlockCountMax) since_rekey_q = since_rekey_q + 16'd1;
    ctr_q = ctr_q + 32'd1;
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [63:0] want;
    if (!rst_ni) begin
      key_q[0] = xcrng_pkg::KeyReset0;
      key_q[1] = xcrng_pkg::KeyReset1;
      key_q[2] = xcrng_pkg::KeyReset2;
      key_q[3] = xcrng_pkg::KeyReset3;
      ctr_q = '0;
      since_rekey_q = '0;
      threshold_q = xcrng_pkg::RekeyReset;
      random_q.delete();
      fails = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) threshold_q = cfg_data_i;
      if (s_valid_i && s_ready_i) random_q.push_back(next_random(s_data_i));
      if (m_valid_i && m_ready_i) begin
        if (random_q.size() == 0) begin
          report_mismatch($sformatf("random_value %h with no timestamp outstanding", m_data_i));
        end else begin
          want = random_q.pop_front();
          if (m_data_i !== want)
            report_mismatch($sformatf("random_value %h, predicted %h", m_data_i, want));
        end
      end
    end
    pending_o <= random_q.size();
  end

endmodule

>>> dv/xtea_counter_mode_rng_test.sv
// xtea_counter_mode_rng_test.sv: top of the xtea generator testbench, drives timestamps and thresholds
`timescale 1ns / 1ps

module xtea_counter_mode_rng_test;

  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_e;

  localparam int unsigned PhaseItems = 115;
  localparam int unsigned HoldCycles = 1500;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data = '0;
  logic        hold_go = 1'b0;
  int unsigned hold_left = 0;
  int unsigned pending;
  int unsigned fail_count;
  idle_e       idle_mode = IdleNone;
  logic [31:0] seconds = '0;

  always #5 clk_i = ~clk_i;

  xtea_counter_mode_rng uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data)
  );

  xtea_rng_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready_o),
    .s_data_i     (s_axis_tdata),
    .m_valid_i    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  function automatic bit rx_stall();
    case (idle_mode)
      IdleReceiver: return $urandom_range(0, 99) < 66;
      IdleBoth:     return $urandom_range(0, 99) < 15;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic bit tx_gap();
    case (idle_mode)
      IdleSender: return $urandom_range(0, 99) < 66;
      IdleBoth:   return $urandom_range(0, 99) < 15;
      default:    return 1'b0;
    endcase
  endfunction

  // receiver side: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_go) begin
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rx_stall();
    end
  end

  function automatic logic [31:0] edge_stamp(input int i);
    case (i)
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0000_0001;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5:       return 32'hFFFF_FFFE;
      6:       return 32'hAAAA_AAAA;
      7:       return 32'h5555_5555;
      8:       return 32'h0000_0000;
      9:       return 32'h0000_0000;
      10:      return 32'hFFFF_FFFF;
      11:      return 32'h0123_4567;
      default: return 32'hFFFF_FFF0 + i;  // ts plus counter wraps past the top
    endcase
  endfunction

  function automatic logic [31:0] rand_stamp();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 15);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
      2, 3: begin
        seconds = seconds + $urandom_range(0, 2);
        return seconds;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_timestamp(input logic [31:0] ts);
    while (tx_gap()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ts;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // lowers valid after the last transfer and waits until every value has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int          p;
    int          i;
    logic [15:0] limit;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset threshold: the first rekey falls on the 22nd value
    for (i = 0; i < 25; i++) send_timestamp(edge_stamp(i));
    drain();

    // zero threshold rekeys on every step
    write_threshold(16'd0);
    for (i = 0; i < 3; i++) send_timestamp(edge_stamp(i));
    drain();
    write_threshold(16'd1);
    for (i = 0; i < 3; i++) send_timestamp(edge_stamp(i + 3));
    drain();

    // threshold lowered below the running count forces a rekey next step
    write_threshold(16'd40);
    for (i = 0; i < 30; i++) send_timestamp(rand_stamp());
    drain();
    write_threshold(16'd5);
    for (i = 0; i < 2; i++) send_timestamp(rand_stamp());
    drain();

    for (p = 0; p < 16; p++) begin
      case (p)
        3:       limit = 16'hFFFF;
        7:       limit = 16'd1;
        11:      limit = 16'd0;
        default: limit = 16'($urandom_range(2, 48));
      endcase
      idle_mode = idle_e'(p % 4);
      write_threshold(limit);
      if (p == 5 || p == 13) begin
        hold_go <= 1'b1;
        @(posedge clk_i);
        hold_go <= 1'b0;
      end
      for (i = 0; i < PhaseItems; i++) send_timestamp(rand_stamp());
      drain();
    end

    repeat (400) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
